// ===== design/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants for the PLL factor search
// Field widths, divider geometry and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int OSC_W  = 26;
  localparam int TGT_W  = 31;
  localparam int MULT_W = 7;
  localparam int DIV_W  = 2;
  localparam int ERR_W  = 32;

  localparam int N_W    = 8;
  localparam int M_W    = 5;
  localparam int PROD_W = OSC_W + N_W;

  localparam int DIGIT_BITS = 8;
  localparam int DIGITS     = (PROD_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DQ_W       = DIGITS * DIGIT_BITS;
  localparam int CNT_W      = $clog2(DIGITS);

  localparam logic [OSC_W-1:0] OSC_RESET = OSC_W'(24000000);

  typedef struct packed {
    logic start;
    logic mul;
    logic step;
    logic cmp;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic stop;
  } dp_sts_t;

endpackage

// ===== design/pll_factor_search_top.sv =====
// ----------------------------------------------------------------------------
// pll_factor_search_top: PLL multiplier/divider search
// Finds the multiplier and divider whose output best matches twice the
// requested frequency.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, osc_hz): oscillator frequency, always
//   ready; write it only while no request is in flight.
//   in channel (in_valid/in_stall, target_hz): one request per search.
//   out channel (out_valid/out_stall, best_mult/best_div/best_error): one
//   result per request, held in an output register until taken.
// Sequence: each candidate pair takes a multiply step, divider steps at
//   eight quotient bits each, and a compare step. At most
//   (MULT_MAX-MULT_MIN+1)*DIV_MAX pairs are searched, 176 by default,
//   fewer on an exact match; the next request is taken once the result
//   is published and the block is back in idle.
// A stalled result does not block the next request; a second result waits
//   in the final state until the output register is free.
// Reset clears the handshakes and loads osc_hz with 24000000.
// ----------------------------------------------------------------------------
module pll_factor_search_top
  import pfs_pkg::*;
#(
  parameter int MULT_MIN = 12,
  parameter int MULT_MAX = 99,
  parameter int DIV_MAX  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [OSC_W-1:0]  osc_hz,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TGT_W-1:0]  target_hz,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MULT_W-1:0] best_mult,
  output logic [DIV_W-1:0]  best_div,
  output logic [ERR_W-1:0]  best_error
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  pfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfs_datapath #(
    .MULT_MIN (MULT_MIN),
    .MULT_MAX (MULT_MAX),
    .DIV_MAX  (DIV_MAX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .osc_in     (osc_hz),
    .target_hz  (target_hz),
    .cmd        (cmd),
    .sts        (sts),
    .best_mult  (best_mult),
    .best_div   (best_div),
    .best_error (best_error)
  );

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but search not started");

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a search in progress");

endmodule

// ===== design/pfs_datapath.sv =====
// ----------------------------------------------------------------------------
// pfs_datapath: candidate evaluation datapath
// Oscillator register, multiplier, digit-serial divider, error and best-pair
// tracking, search indices and the result register.
// ----------------------------------------------------------------------------
module pfs_datapath
  import pfs_pkg::*;
#(
  parameter int MULT_MIN = 12,
  parameter int MULT_MAX = 99,
  parameter int DIV_MAX  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [OSC_W-1:0]  osc_in,
  input  logic [TGT_W-1:0]  target_hz,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic [MULT_W-1:0] best_mult,
  output logic [DIV_W-1:0]  best_div,
  output logic [ERR_W-1:0]  best_error
);

  localparam logic [N_W-1:0] N_MIN = N_W'(MULT_MIN);
  localparam logic [N_W-1:0] N_MAX = N_W'(MULT_MAX);
  localparam logic [M_W-1:0] M_MAX = M_W'(DIV_MAX);
  localparam logic [M_W-1:0] M_ONE = M_W'(1);

  logic [OSC_W-1:0]  osc;
  logic [ERR_W-1:0]  goal;
  logic [N_W-1:0]    n;
  logic [M_W-1:0]    m;
  logic [CNT_W-1:0]  cnt;
  logic [M_W-2:0]    rem;
  logic [DQ_W-1:0]   dq;
  logic [N_W-1:0]    best_n;
  logic [M_W-1:0]    best_m;
  logic [ERR_W-1:0]  best_e;

  logic [PROD_W-1:0] prod;
  logic [M_W-2:0]    r;
  logic [M_W-1:0]    t;
  logic [M_W-1:0]    d;
  logic [DIGIT_BITS-1:0] qd;
  logic [PROD_W-1:0] freq;
  logic [PROD_W-1:0] goal_x;
  logic [PROD_W-1:0] diff;
  logic [ERR_W-1:0]  err;
  logic              upd;
  logic              last;

  assign prod = {{(PROD_W-OSC_W){1'b0}}, osc} * {{(PROD_W-N_W){1'b0}}, n};

  // restoring division by m, one quotient byte per cycle
  always_comb begin
    r  = rem;
    t  = '0;
    d  = '0;
    qd = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      t = {r, dq[DQ_W-1-i]};
      d = t - m;
      if (t >= m) begin
        r = d[M_W-2:0];
        qd[DIGIT_BITS-1-i] = 1'b1;
      end else begin
        r = t[M_W-2:0];
      end
    end
  end

  assign freq   = dq[PROD_W-1:0];
  assign goal_x = {{(PROD_W-ERR_W){1'b0}}, goal};
  assign diff   = (freq >= goal_x) ? (freq - goal_x) : (goal_x - freq);
  assign err    = (|diff[PROD_W-1:ERR_W]) ? '1 : diff[ERR_W-1:0];
  assign upd    = err < best_e;
  assign last   = (n == N_MAX) && (m == M_MAX);

  assign sts.empty    = N_MIN > N_MAX;
  assign sts.div_done = cnt == CNT_W'(DIGITS - 1);
  assign sts.stop     = (upd && (err == '0)) || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      osc <= OSC_RESET;
    end else if (cfg_we) begin
      osc <= osc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      goal   <= {target_hz, 1'b0};
      n      <= N_MIN;
      m      <= M_ONE;
      best_n <= N_MIN;
      best_m <= M_ONE;
      best_e <= '1;
    end
    if (cmd.mul) begin
      dq  <= DQ_W'(prod);
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.step) begin
      dq  <= {dq[DQ_W-DIGIT_BITS-1:0], qd};
      rem <= r;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.cmp) begin
      if (upd) begin
        best_n <= n;
        best_m <= m;
        best_e <= err;
      end
      if (m == M_MAX) begin
        n <= n + N_W'(1);
        m <= M_ONE;
      end else begin
        m <= m + M_ONE;
      end
    end
    if (cmd.publish) begin
      best_mult  <= best_n[MULT_W-1:0];
      best_div   <= best_m[DIV_W-1:0];
      best_error <= best_e;
    end
  end

endmodule

// ===== design/pfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfs_ctrl: search sequencer
// Steps each candidate pair through multiply, divide and compare, and owns
// the request and result handshakes.
// ----------------------------------------------------------------------------
module pfs_ctrl
  import pfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.empty ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.stop ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
